// ===== src/ip_address_text_validator_assert.svh =====
// Assertion macros for the address text validator checks
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define IATV_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("iatv check failed");

// next-cycle implication, off during reset
`define IATV_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("iatv check failed");

// next-cycle implication, live through reset
`define IATV_ASSERT_RST(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("iatv check failed");

`endif

// ===== src/iatv_pkg.sv =====
// Shared types and constants for the address text validator
package iatv_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  localparam logic [3:0] V4_SECTIONS  = 4'd4;
  localparam logic [3:0] V6_SECTIONS  = 4'd8;
  localparam logic [3:0] COUNT_MAX    = 4'd15;
  localparam logic [2:0] V4_MAX_LEN   = 3'd3;
  localparam logic [2:0] V6_MAX_LEN   = 3'd4;
  localparam logic [2:0] LEN_SAT      = 3'd5;
  localparam logic [9:0] V4_MAX_VALUE = 10'd255;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_V4   = 2'd1;
  localparam logic [1:0] VERDICT_V6   = 2'd2;

  typedef enum logic [2:0] {
    CLS_DOT,
    CLS_COLON,
    CLS_DEC,
    CLS_HEX,
    CLS_ALPHA,
    CLS_BAD
  } char_class_t;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_DOT,
    SEP_COLON
  } sep_kind_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } char_item_t;

endpackage

// ===== src/iatv_front.sv =====
// Front end: takes characters and classifies them into queue entries
module iatv_front import iatv_pkg::*; (
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic       q_full,
  output logic       q_push,
  output char_item_t q_item
);

  logic is_dec;
  logic is_lo_hex;
  logic is_up_hex;
  logic is_lo;
  logic is_up;

  assign is_dec    = (in_char_code >= 8'h30) && (in_char_code <= 8'h39);
  assign is_lo     = (in_char_code >= 8'h61) && (in_char_code <= 8'h7A);
  assign is_up     = (in_char_code >= 8'h41) && (in_char_code <= 8'h5A);
  assign is_lo_hex = (in_char_code >= 8'h61) && (in_char_code <= 8'h66);
  assign is_up_hex = (in_char_code >= 8'h41) && (in_char_code <= 8'h46);

  assign in_ready = rst_n && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.digit = in_char_code[3:0];
    q_item.last  = in_last_char;
    if (in_char_code == DOT_CHAR) begin
      q_item.cls = CLS_DOT;
    end else if (in_char_code == COLON_CHAR) begin
      q_item.cls = CLS_COLON;
    end else if (is_dec) begin
      q_item.cls = CLS_DEC;
    end else if (is_lo_hex || is_up_hex) begin
      q_item.cls = CLS_HEX;
    end else if (is_lo || is_up) begin
      q_item.cls = CLS_ALPHA;
    end else begin
      q_item.cls = CLS_BAD;
    end
  end

endmodule

// ===== src/iatv_fifo.sv =====
// Short queue of classified characters between front and back
module iatv_fifo import iatv_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  char_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output char_item_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  char_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign avail = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/iatv_back.sv =====
// Back end: section state update, verdict and output register
module iatv_back import iatv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  char_item_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  typedef struct packed {
    logic       bad;
    logic [3:0] count;
  } fin_t;

  function automatic fin_t finish(input sep_kind_t kind, input logic [2:0] len,
                                  input logic [9:0] val, input logic lz,
                                  input logic nd, input logic nh,
                                  input logic [3:0] cnt);
    logic       good;
    logic [3:0] limit;
    logic [3:0] inc;
    fin_t       res;
    good  = 1'b0;
    limit = '0;
    case (kind)
      SEP_DOT: begin
        good  = (len >= 3'd1) && (len <= V4_MAX_LEN) && !((len > 3'd1) && lz) &&
                !nd && (val <= V4_MAX_VALUE);
        limit = V4_SECTIONS;
      end
      SEP_COLON: begin
        good  = (len >= 3'd1) && (len <= V6_MAX_LEN) && !nh;
        limit = V6_SECTIONS;
      end
      default: begin
        good  = 1'b0;
        limit = '0;
      end
    endcase
    inc       = (cnt == COUNT_MAX) ? cnt : cnt + 4'd1;
    res.bad   = !good || (inc > limit);
    res.count = inc;
    return res;
  endfunction

  sep_kind_t  sep_r, sep_nxt;
  logic [3:0] count_r, count_nxt;
  logic [2:0] len_r, len_nxt;
  logic [9:0] value_r, value_nxt;
  logic       lz_r, lz_nxt;
  logic       nd_r, nd_nxt;
  logic       nh_r, nh_nxt;
  logic       failed_r, failed_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] verdict_r, verdict_nxt;
  logic [1:0] verdict_c;

  assign q_pop       = q_avail && (!q_head.last || !out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  always_comb begin
    sep_kind_t kind;
    fin_t      fin;
    kind       = SEP_NONE;
    fin        = '0;
    sep_nxt    = sep_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    value_nxt  = value_r;
    lz_nxt     = lz_r;
    nd_nxt     = nd_r;
    nh_nxt     = nh_r;
    failed_nxt = failed_r;
    verdict_c  = VERDICT_NONE;

    if (!failed_r) begin
      case (q_head.cls)
        CLS_DOT, CLS_COLON: begin
          kind = (q_head.cls == CLS_DOT) ? SEP_DOT : SEP_COLON;
          if ((sep_r != SEP_NONE) && (sep_r != kind)) begin
            failed_nxt = 1'b1;
          end else begin
            sep_nxt = kind;
            fin     = finish(kind, len_r, value_r, lz_r, nd_r, nh_r, count_r);
            if (fin.bad) begin
              failed_nxt = 1'b1;
            end else begin
              count_nxt = fin.count;
              len_nxt   = '0;
              value_nxt = '0;
              lz_nxt    = 1'b0;
              nd_nxt    = 1'b0;
              nh_nxt    = 1'b0;
            end
          end
        end
        CLS_DEC, CLS_HEX, CLS_ALPHA: begin
          if (len_r == 3'd0) begin
            lz_nxt = (q_head.cls == CLS_DEC) && (q_head.digit == 4'd0);
          end
          if (q_head.cls != CLS_DEC) begin
            nd_nxt = 1'b1;
          end else if (len_r < V4_MAX_LEN) begin
            value_nxt = (value_r << 3) + (value_r << 1) + {6'd0, q_head.digit};
          end
          if (q_head.cls == CLS_ALPHA) begin
            nh_nxt = 1'b1;
          end
          if (len_r < LEN_SAT) begin
            len_nxt = len_r + 3'd1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end

    if (q_head.last) begin
      if (!failed_nxt) begin
        fin = finish(sep_nxt, len_nxt, value_nxt, lz_nxt, nd_nxt, nh_nxt, count_nxt);
        if (!fin.bad) begin
          if ((sep_nxt == SEP_DOT) && (fin.count == V4_SECTIONS)) begin
            verdict_c = VERDICT_V4;
          end else if ((sep_nxt == SEP_COLON) && (fin.count == V6_SECTIONS)) begin
            verdict_c = VERDICT_V6;
          end
        end
      end
      sep_nxt    = SEP_NONE;
      count_nxt  = '0;
      len_nxt    = '0;
      value_nxt  = '0;
      lz_nxt     = 1'b0;
      nd_nxt     = 1'b0;
      nh_nxt     = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    if (q_pop && q_head.last) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = verdict_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_NONE;
      count_r     <= '0;
      len_r       <= '0;
      value_r     <= '0;
      lz_r        <= 1'b0;
      nd_r        <= 1'b0;
      nh_r        <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        sep_r    <= sep_nxt;
        count_r  <= count_nxt;
        len_r    <= len_nxt;
        value_r  <= value_nxt;
        lz_r     <= lz_nxt;
        nd_r     <= nd_nxt;
        nh_r     <= nh_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

endmodule

// ===== src/ip_address_text_validator.sv =====
// Address text validator: one character per transaction in, one verdict per string out.
// The block takes one character per clock and returns one verdict per string, on the
// transaction that carries the last character. The front end classifies each character
// and writes it into a small queue (DEPTH entries); the back end pops one entry a cycle,
// updates the section state and loads the verdict into an output register. Sustained
// rate is one character per cycle; out_valid rises once the last character has passed
// the queue and the output register. Only a held verdict blocks the back end, and
// only on the next string's last character; the queue then fills with that character and
// DEPTH-1 more before in_ready drops. Verdicts: 0 neither, 1 valid IPv4, 2 valid IPv6.
module ip_address_text_validator import iatv_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_avail;
  char_item_t q_in;
  char_item_t q_head;

  iatv_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  iatv_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  iatv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_avail     (q_avail),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

endmodule

// ===== src/iatv_checker.sv =====
// Port-level checks for the address text validator, bound to the top level
`include "ip_address_text_validator_assert.svh"

module iatv_checker import iatv_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict
);

  logic verdict_ok;
  logic out_stall;

  assign verdict_ok = (out_verdict == VERDICT_NONE) || (out_verdict == VERDICT_V4) ||
                      (out_verdict == VERDICT_V6);
  assign out_stall  = out_valid && !out_ready;

  `IATV_ASSERT_IMP(a_verdict_code, clk, rst_n, out_valid, verdict_ok)
  `IATV_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_verdict))
  `IATV_ASSERT_RST(a_rst_out_idle, clk, !rst_n, !out_valid)
  `IATV_ASSERT_RST(a_rst_in_ready, clk, !rst_n, rst_n == in_ready)

endmodule

bind ip_address_text_validator iatv_checker u_iatv_checker (.*);
